// ===== hdl/rgft_pkg.sv =====
// Shared types, constants and the index step table for the readability grade core.
package rgft_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int OUT_BITS       = 16;

    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_EXCLAIM  = 8'd33;
    localparam logic [7:0] CH_PERIOD   = 8'd46;
    localparam logic [7:0] CH_QUESTION = 8'd63;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7a;

    localparam logic [1:0] CAT_LOW    = 2'd0;
    localparam logic [1:0] CAT_GRADED = 2'd1;
    localparam logic [1:0] CAT_HIGH   = 2'd2;

    localparam logic [1:0] SRC_L = 2'd0;
    localparam logic [1:0] SRC_S = 2'd1;
    localparam logic [1:0] SRC_W = 2'd2;

    localparam int STEPS  = 16;
    localparam int STEP_W = $clog2(STEPS);
    localparam int Q_W    = 6;
    localparam logic [Q_W-1:0] Q_LOW = 6'd3;
    localparam logic [Q_W-1:0] Q_MAX = 6'd33;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [1:0]          category;
        logic [4:0]          grade_level;
        logic [OUT_BITS-1:0] letters_seen;
        logic [OUT_BITS-1:0] words_seen;
        logic [OUT_BITS-1:0] sentences_seen;
    } t_out;

    typedef struct packed {
        logic       fin;
        logic [1:0] category;
        logic [4:0] grade;
    } t_calc_res;

    typedef struct packed {
        logic [1:0] src;
        logic [3:0] shift;
        logic       neg;
        logic       to_d;
    } t_step;

    // acc = 1176*L - 5920*S - 3060*W, d = 100*W
    function automatic t_step step_entry(input logic [STEP_W-1:0] idx);
        t_step s;
        case (idx)
            4'd0:    s = '{SRC_L, 4'd10, 1'b0, 1'b0};
            4'd1:    s = '{SRC_L, 4'd7,  1'b0, 1'b0};
            4'd2:    s = '{SRC_L, 4'd4,  1'b0, 1'b0};
            4'd3:    s = '{SRC_L, 4'd3,  1'b0, 1'b0};
            4'd4:    s = '{SRC_S, 4'd12, 1'b1, 1'b0};
            4'd5:    s = '{SRC_S, 4'd10, 1'b1, 1'b0};
            4'd6:    s = '{SRC_S, 4'd9,  1'b1, 1'b0};
            4'd7:    s = '{SRC_S, 4'd8,  1'b1, 1'b0};
            4'd8:    s = '{SRC_S, 4'd5,  1'b1, 1'b0};
            4'd9:    s = '{SRC_W, 4'd11, 1'b1, 1'b0};
            4'd10:   s = '{SRC_W, 4'd10, 1'b1, 1'b0};
            4'd11:   s = '{SRC_W, 4'd3,  1'b0, 1'b0};
            4'd12:   s = '{SRC_W, 4'd2,  1'b0, 1'b0};
            4'd13:   s = '{SRC_W, 4'd6,  1'b0, 1'b1};
            4'd14:   s = '{SRC_W, 4'd5,  1'b0, 1'b1};
            4'd15:   s = '{SRC_W, 4'd2,  1'b0, 1'b1};
            default: s = '{SRC_W, 4'd0,  1'b0, 1'b0};
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/readability_grade_from_text_core.sv =====
// Top level of the Coleman-Liau readability grade core: counters, sequencer, result register.
//
//  channel  | handshake              | payload         | transfer when
//  ---------+------------------------+-----------------+---------------------------
//  input    | start / busy           | i_in  (t_in)    | start high and busy low
//  result   | o_done strobe          | o_out (t_out)   | every cycle o_done is high
//
// A byte without last is counted and busy stays low.
// A byte with last sets busy; rgft_calc then runs 16 shift-add steps and repeated-subtract
// grading that finds the quotient q, q <= 33; the shared adder in rgft_calc serialises them.
// The result strobes for one cycle as busy drops; a new byte may transfer in that cycle.
// Reset clears the counters and the sequencer; the receiver cannot stall.
module readability_grade_from_text_core
    import rgft_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_done,
    output t_out o_out
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_letters, n_letters;
    logic [COUNT_BITS-1:0] r_spaces,  n_spaces;
    logic [COUNT_BITS-1:0] r_sent,    n_sent;
    logic                  r_busy,    n_busy;
    logic                  r_done,    n_done;
    t_out                  r_out,     n_out;

    logic                  accept;
    logic                  is_letter;
    logic                  is_space;
    logic                  is_sent;
    logic [COUNT_BITS-1:0] words;
    t_calc_res             calc;

    assign accept = start && !r_busy;
    assign words  = (r_spaces == CNT_MAX) ? CNT_MAX : r_spaces + COUNT_BITS'(1);

    always_comb begin
        is_letter = i_in.char_code inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
        is_space  = i_in.char_code == CH_SPACE;
        is_sent   = i_in.char_code inside {CH_EXCLAIM, CH_PERIOD, CH_QUESTION};
    end

    rgft_calc #(
        .COUNT_BITS(COUNT_BITS)
    ) u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (accept && i_in.last),
        .i_letters  (r_letters),
        .i_sentences(r_sent),
        .i_words    (words),
        .o_res      (calc)
    );

    always_comb begin
        n_letters = r_letters;
        n_spaces  = r_spaces;
        n_sent    = r_sent;
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_out     = r_out;
        if (accept) begin
            if (is_letter && r_letters != CNT_MAX) begin
                n_letters = r_letters + COUNT_BITS'(1);
            end
            if (is_space && r_spaces != CNT_MAX) begin
                n_spaces = r_spaces + COUNT_BITS'(1);
            end
            if (is_sent && r_sent != CNT_MAX) begin
                n_sent = r_sent + COUNT_BITS'(1);
            end
            if (i_in.last) begin
                n_busy = 1'b1;
            end
        end
        if (r_busy && calc.fin) begin
            n_out.category       = calc.category;
            n_out.grade_level    = calc.grade;
            n_out.letters_seen   = OUT_BITS'(r_letters);
            n_out.words_seen     = OUT_BITS'(words);
            n_out.sentences_seen = OUT_BITS'(r_sent);
            n_done    = 1'b1;
            n_busy    = 1'b0;
            n_letters = '0;
            n_spaces  = '0;
            n_sent    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letters <= '0;
            r_spaces  <= '0;
            r_sent    <= '0;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_letters <= n_letters;
            r_spaces  <= n_spaces;
            r_sent    <= n_sent;
            r_busy    <= n_busy;
            r_done    <= n_done;
        end
        r_out <= n_out;
    end

    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_out  = r_out;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a busy cycle before it");

    a_last_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.last) |=> busy)
        else $error("last byte transfer did not start the calculation");

    a_cat_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.category == CAT_LOW || o_out.category == CAT_GRADED
                    || o_out.category == CAT_HIGH))
        else $error("category code out of range");

    a_grade_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.category != CAT_GRADED) |-> (o_out.grade_level == 5'd0))
        else $error("grade level nonzero outside graded category");

    a_grade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.category == CAT_GRADED)
            |-> (o_out.grade_level != 5'd0 && o_out.grade_level <= 5'd16))
        else $error("graded result outside one to sixteen");

endmodule

// ===== hdl/rgft_calc.sv =====
// Shift-add sequencer and repeated-subtract grader sharing one adder.
module rgft_calc
    import rgft_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [COUNT_BITS-1:0] i_letters,
    input  logic [COUNT_BITS-1:0] i_sentences,
    input  logic [COUNT_BITS-1:0] i_words,
    output t_calc_res             o_res
);

    localparam int ACC_W = COUNT_BITS + 16;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_SUM  = 2'd1;
    localparam logic [1:0] C_DIV  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [Q_W-1:0]    r_q,     n_q;
    logic [ACC_W-1:0]  r_acc,   n_acc;
    logic [ACC_W-1:0]  r_d,     n_d;

    t_step              st;
    logic [COUNT_BITS-1:0] src;
    logic [ACC_W-1:0]   op;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W-1:0]   opx;
    logic [ACC_W-1:0]   sum;
    logic               stop;

    always_comb begin
        st = step_entry(r_step);
        case (st.src)
            SRC_L:   src = i_letters;
            SRC_S:   src = i_sentences;
            default: src = i_words;
        endcase
        op = ACC_W'(src) << st.shift;
        if (r_state == C_DIV) begin
            addend = r_acc;
            opx    = ~r_d + ACC_W'(1);
        end else begin
            addend = st.to_d ? r_d : r_acc;
            opx    = st.neg ? (~op + ACC_W'(1)) : op;
        end
        sum  = addend + opx;
        stop = sum[ACC_W-1] || (r_q == Q_MAX);
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_q     = r_q;
        n_acc   = r_acc;
        n_d     = r_d;
        case (r_state)
            C_IDLE: begin
                if (i_go) begin
                    n_state = C_SUM;
                    n_step  = '0;
                    n_q     = '0;
                    n_acc   = '0;
                    n_d     = '0;
                end
            end
            C_SUM: begin
                if (st.to_d) begin
                    n_d = sum;
                end else begin
                    n_acc = sum;
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = C_DIV;
                end
            end
            C_DIV: begin
                if (stop) begin
                    n_state = C_IDLE;
                end else begin
                    n_acc = sum;
                    n_q   = r_q + Q_W'(1);
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_step  <= '0;
            r_q     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_q     <= n_q;
        end
        r_acc <= n_acc;
        r_d   <= n_d;
    end

    always_comb begin
        o_res.fin = (r_state == C_DIV) && stop;
        if (r_q < Q_LOW) begin
            o_res.category = CAT_LOW;
            o_res.grade    = '0;
        end else if (r_q >= Q_MAX) begin
            o_res.category = CAT_HIGH;
            o_res.grade    = '0;
        end else begin
            o_res.category = CAT_GRADED;
            o_res.grade    = r_q[Q_W-1:1];
        end
    end

endmodule
